/* design/gpt_pkg.sv */
package gpt_pkg;

  localparam int unsigned UNIFORM_BITS_DEF = 16;

  localparam int unsigned NORM_W   = 32;
  localparam int unsigned SHIFT_W  = 5;
  localparam int unsigned NL2_W    = 38;
  localparam int unsigned T_W      = 40;
  localparam int unsigned DIV_SHIFT = 24;
  localparam int unsigned Q_W      = T_W + DIV_SHIFT;
  localparam int unsigned ROOT_W   = 32;
  localparam int unsigned K_W      = 36;
  localparam int unsigned K_SPLIT  = 18;
  localparam int unsigned MEAN_W   = 32;
  localparam int unsigned STD_W    = 24;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned MAG_W    = 40;
  localparam int unsigned SUM_W    = 42;

  localparam logic [31:0]        LN2_Q32       = 32'hB17217F8;
  localparam logic [MEAN_W-1:0]  MEAN_RESET    = 32'h0000_0000;
  localparam logic [STD_W-1:0]   STD_DEV_RESET = 24'd1638400;

  typedef enum logic [0:0] {
    CFG_MEAN    = 1'b0,
    CFG_STD_DEV = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic valid;
    logic [SAMPLE_W-1:0] first;
    logic [SAMPLE_W-1:0] second;
  } pair_t;

endpackage

/* design/gaussian_polar_transform_core.sv */
// A pair passes square, log, divide, sqrt and scale to the first sample beat; the second
// sample beat follows once the first is taken. Rejected pairs produce no beat.
// Throughput: one input beat per cycle into the log/divide/sqrt pipeline unless stalled;
// the single output port delivers two beats per accepted pair, which stalls the whole pipeline.
// Reset: asynchronous active low; clears all valid bits, mean to 0, std_dev to 25.0.
module gaussian_polar_transform_core #(
  parameter int unsigned UNIFORM_BITS = gpt_pkg::UNIFORM_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_index_i,
  input  logic [gpt_pkg::MEAN_W-1:0]     cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [UNIFORM_BITS-1:0] first_uniform_i,
  input  logic signed [UNIFORM_BITS-1:0] second_uniform_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [gpt_pkg::SAMPLE_W-1:0] sample_o,
  output logic                           last_o
);

  localparam int unsigned UB    = UNIFORM_BITS;
  localparam int unsigned TWO_F = 2 * (UB - 1);
  localparam int unsigned WW    = 2 * UB;
  localparam int unsigned NW    = gpt_pkg::NORM_W;
  localparam int unsigned TAG_W = 2 * UB;

  logic [gpt_pkg::MEAN_W-1:0] mean_q;
  logic [gpt_pkg::STD_W-1:0]  std_dev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q    <= gpt_pkg::MEAN_RESET;
      std_dev_q <= gpt_pkg::STD_DEV_RESET;
    end else if (cfg_we_i) begin
      unique case (gpt_pkg::cfg_reg_e'(cfg_index_i))
        gpt_pkg::CFG_MEAN:    mean_q    <= cfg_wdata_i;
        gpt_pkg::CFG_STD_DEV: std_dev_q <= cfg_wdata_i[gpt_pkg::STD_W-1:0];
        default: ;
      endcase
    end
  end

  logic en;
  gpt_pkg::pair_t out_q;
  logic out_sel_q;

  assign en = !out_q.valid || (out_ready_i && out_sel_q);

  logic                 v0_q, v1_q, v2_q;
  logic signed [UB-1:0] x1_0_q, x2_0_q, x1_1_q, x2_1_q;
  logic [WW-2:0]        sq1_q, sq2_q;
  logic [WW-1:0]        w;
  logic [WW+NW-1:0]     w_ext;
  logic [NW-1:0]        w_norm;
  logic                 reject;
  logic [NW-1:0]        w2_q;
  logic [TAG_W-1:0]     tag2_q;
  logic signed [WW-1:0] sq1_full, sq2_full;

  assign sq1_full = x1_0_q * x1_0_q;
  assign sq2_full = x2_0_q * x2_0_q;
  assign w        = {1'b0, sq1_q} + {1'b0, sq2_q};
  assign w_ext    = {w, {NW{1'b0}}} >> TWO_F;
  assign w_norm   = (w_ext[NW-1:0] == '0) ? NW'(1) : w_ext[NW-1:0];
  assign reject   = (w == '0) || (w[WW-1:TWO_F] != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
      v1_q <= v0_q;
      v2_q <= v1_q && !reject;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x1_0_q <= first_uniform_i;
      x2_0_q <= second_uniform_i;
      sq1_q  <= sq1_full[WW-2:0];
      sq2_q  <= sq2_full[WW-2:0];
      x1_1_q <= x1_0_q;
      x2_1_q <= x2_0_q;
      w2_q   <= w_norm;
      tag2_q <= {x1_1_q, x2_1_q};
    end
  end

  logic                       log_v, div_v, sqrt_v;
  logic [gpt_pkg::T_W-1:0]    log_t;
  logic [NW-1:0]              log_w;
  logic [TAG_W-1:0]           log_tag, div_tag, sqrt_tag;
  logic [gpt_pkg::Q_W-1:0]    div_q;
  logic [gpt_pkg::K_W-1:0]    sqrt_k;

  gpt_log #(.TAG_W(TAG_W)) u_log (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(v2_q), .w_i(w2_q), .tag_i(tag2_q),
    .valid_o(log_v), .t_o(log_t), .w_o(log_w), .tag_o(log_tag)
  );

  gpt_div #(.TAG_W(TAG_W)) u_div (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(log_v), .t_i(log_t), .w_i(log_w), .tag_i(log_tag),
    .valid_o(div_v), .q_o(div_q), .tag_o(div_tag)
  );

  gpt_sqrt #(.TAG_W(TAG_W)) u_sqrt (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(div_v), .q_i(div_q), .tag_i(div_tag),
    .valid_o(sqrt_v), .k_o(sqrt_k), .tag_o(sqrt_tag)
  );

  logic                        s1_v, s2_v;
  logic [gpt_pkg::SAMPLE_W-1:0] s1, s2;

  gpt_scale #(.UNIFORM_BITS(UB)) u_scale_first (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(sqrt_v), .x_i(sqrt_tag[TAG_W-1:UB]), .k_i(sqrt_k),
    .mean_i(mean_q), .std_dev_i(std_dev_q),
    .valid_o(s1_v), .sample_o(s1)
  );

  gpt_scale #(.UNIFORM_BITS(UB)) u_scale_second (
    .clk_i, .rst_ni, .en_i(en),
    .valid_i(sqrt_v), .x_i(sqrt_tag[UB-1:0]), .k_i(sqrt_k),
    .mean_i(mean_q), .std_dev_i(std_dev_q),
    .valid_o(s2_v), .sample_o(s2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q     <= '0;
      out_sel_q <= 1'b0;
    end else if (en) begin
      out_q     <= '{valid: s1_v && s2_v, first: s1, second: s2};
      out_sel_q <= 1'b0;
    end else if (out_ready_i) begin
      out_sel_q <= 1'b1;
    end
  end

  assign in_ready_o  = en;
  assign out_valid_o = out_q.valid;
  assign sample_o    = out_sel_q ? out_q.second : out_q.first;
  assign last_o      = out_sel_q;

`ifndef SYNTHESIS
  a_second_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o && last_o)
    else $error("second beat of a pair missing");

  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !(out_ready_i && last_o) |-> !in_ready_o)
    else $error("pipeline advanced while a pair was pending");

  a_last_after_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(last_o) |-> $past(out_valid_o && out_ready_i))
    else $error("last raised without a taken first beat");
`endif

endmodule

/* design/gpt_log.sv */
module gpt_log #(
  parameter int unsigned TAG_W = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic [gpt_pkg::NORM_W-1:0] w_i,
  input  logic [TAG_W-1:0]          tag_i,
  output logic                      valid_o,
  output logic [gpt_pkg::T_W-1:0]   t_o,
  output logic [gpt_pkg::NORM_W-1:0] w_o,
  output logic [TAG_W-1:0]          tag_o
);

  localparam int unsigned NW = gpt_pkg::NORM_W;
  localparam int unsigned SW = gpt_pkg::SHIFT_W;
  localparam int unsigned NS = NW;

  logic                a_v_q;
  logic [NW-1:0]       a_w_q;
  logic [SW-1:0]       a_n_q;
  logic [TAG_W-1:0]    a_tag_q;
  logic [SW-1:0]       clz_d;

  always_comb begin
    clz_d = '0;
    for (int i = 0; i < NW; i++) begin
      if (w_i[i]) begin
        clz_d = SW'(NW - 1 - i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_w_q   <= w_i;
      a_n_q   <= clz_d;
      a_tag_q <= tag_i;
    end
  end

  logic             c_v_q   [NS+1];
  logic [NW-1:0]    c_y_q   [NS+1];
  logic [NW-1:0]    c_frac_q[NS+1];
  logic [SW-1:0]    c_n_q   [NS+1];
  logic [NW-1:0]    c_w_q   [NS+1];
  logic [TAG_W-1:0] c_tag_q [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q[0] <= 1'b0;
    end else if (en_i) begin
      c_v_q[0] <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c_y_q[0]    <= a_w_q << a_n_q;
      c_frac_q[0] <= '0;
      c_n_q[0]    <= a_n_q;
      c_w_q[0]    <= a_w_q;
      c_tag_q[0]  <= a_tag_q;
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_sq
    logic [2*NW-1:0] prod;
    logic [NW:0]     yn;
    logic [NW-1:0]   y_d;
    logic [NW-1:0]   frac_d;

    always_comb begin
      prod   = c_y_q[j] * c_y_q[j];
      yn     = prod[2*NW-1:NW-1];
      frac_d = c_frac_q[j];
      if (yn[NW]) begin
        y_d               = yn[NW:1];
        frac_d[NW-1-j]    = 1'b1;
      end else begin
        y_d = yn[NW-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        c_v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        c_v_q[j+1] <= c_v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        c_y_q[j+1]    <= y_d;
        c_frac_q[j+1] <= frac_d;
        c_n_q[j+1]    <= c_n_q[j];
        c_w_q[j+1]    <= c_w_q[j];
        c_tag_q[j+1]  <= c_tag_q[j];
      end
    end
  end

  logic                          d_v_q, e_v_q, f_v_q;
  logic [gpt_pkg::NL2_W-1:0]     nl2_q;
  logic [gpt_pkg::NL2_W-1:0]     hi_q;
  logic [2*NW-1:0]               lo_q;
  logic [gpt_pkg::T_W-1:0]       t_q;
  logic [NW-1:0]                 d_w_q, e_w_q, f_w_q;
  logic [TAG_W-1:0]              d_tag_q, e_tag_q, f_tag_q;
  logic [SW:0]                   n_inc;
  logic [gpt_pkg::NL2_W-2:0]     sum_d;

  assign n_inc = {1'b0, c_n_q[NS]} + (SW+1)'(1);
  assign sum_d = hi_q[gpt_pkg::NL2_W-2:0]
               + (gpt_pkg::NL2_W-1)'(lo_q[2*NW-1:NW]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
    end else if (en_i) begin
      d_v_q <= c_v_q[NS];
      e_v_q <= d_v_q;
      f_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nl2_q   <= {n_inc, {NW{1'b0}}} - {{(SW+1){1'b0}}, c_frac_q[NS]};
      d_w_q   <= c_w_q[NS];
      d_tag_q <= c_tag_q[NS];
      hi_q    <= gpt_pkg::NL2_W'(nl2_q[gpt_pkg::NL2_W-1:NW])
               * gpt_pkg::NL2_W'(gpt_pkg::LN2_Q32);
      lo_q    <= nl2_q[NW-1:0] * gpt_pkg::LN2_Q32;
      e_w_q   <= d_w_q;
      e_tag_q <= d_tag_q;
      t_q     <= gpt_pkg::T_W'({sum_d, 1'b0});
      f_w_q   <= e_w_q;
      f_tag_q <= e_tag_q;
    end
  end

  assign valid_o = f_v_q;
  assign t_o     = t_q;
  assign w_o     = f_w_q;
  assign tag_o   = f_tag_q;

endmodule

/* design/gpt_div.sv */
module gpt_div #(
  parameter int unsigned TAG_W = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [gpt_pkg::T_W-1:0]    t_i,
  input  logic [gpt_pkg::NORM_W-1:0] w_i,
  input  logic [TAG_W-1:0]           tag_i,
  output logic                       valid_o,
  output logic [gpt_pkg::Q_W-1:0]    q_o,
  output logic [TAG_W-1:0]           tag_o
);

  localparam int unsigned QW = gpt_pkg::Q_W;
  localparam int unsigned NW = gpt_pkg::NORM_W;

  logic             v_q   [QW+1];
  logic [NW-1:0]    rem_q [QW+1];
  logic [QW-1:0]    dq_q  [QW+1];
  logic [NW-1:0]    w_q   [QW+1];
  logic [TAG_W-1:0] tag_q [QW+1];

  assign v_q[0]   = valid_i;
  assign rem_q[0] = '0;
  assign dq_q[0]  = {t_i, {gpt_pkg::DIV_SHIFT{1'b0}}};
  assign w_q[0]   = w_i;
  assign tag_q[0] = tag_i;

  for (genvar j = 0; j < QW; j++) begin : g_step
    logic [NW:0] cur;
    logic [NW:0] nrem;
    logic        ge;

    always_comb begin
      cur  = {rem_q[j], dq_q[j][QW-1]};
      ge   = cur >= {1'b0, w_q[j]};
      nrem = ge ? cur - {1'b0, w_q[j]} : cur;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1] <= nrem[NW-1:0];
        dq_q[j+1]  <= {dq_q[j][QW-2:0], ge};
        w_q[j+1]   <= w_q[j];
        tag_q[j+1] <= tag_q[j];
      end
    end
  end

  assign valid_o = v_q[QW];
  assign q_o     = dq_q[QW];
  assign tag_o   = tag_q[QW];

endmodule

/* design/gpt_sqrt.sv */
module gpt_sqrt #(
  parameter int unsigned TAG_W = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [gpt_pkg::Q_W-1:0] q_i,
  input  logic [TAG_W-1:0]        tag_i,
  output logic                    valid_o,
  output logic [gpt_pkg::K_W-1:0] k_o,
  output logic [TAG_W-1:0]        tag_o
);

  localparam int unsigned QW = gpt_pkg::Q_W;
  localparam int unsigned RW = gpt_pkg::ROOT_W;
  localparam int unsigned NS = QW / 2;
  localparam int unsigned REM_W = RW + 2;

  logic             big;
  logic             v_q    [NS+1];
  logic             big_q  [NS+1];
  logic [REM_W-1:0] rem_q  [NS+1];
  logic [RW-1:0]    root_q [NS+1];
  logic [QW-1:0]    sv_q   [NS+1];
  logic [TAG_W-1:0] tag_q  [NS+1];

  assign big       = |q_i[QW-1:QW-8];
  assign v_q[0]    = valid_i;
  assign big_q[0]  = big;
  assign rem_q[0]  = '0;
  assign root_q[0] = '0;
  assign sv_q[0]   = big ? q_i : {q_i[QW-9:0], 8'h00};
  assign tag_q[0]  = tag_i;

  for (genvar j = 0; j < NS; j++) begin : g_step
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] nrem;
    logic             ge;

    always_comb begin
      cur   = {rem_q[j], sv_q[j][QW-1:QW-2]};
      trial = {2'b00, root_q[j], 2'b01};
      ge    = cur >= trial;
      nrem  = ge ? cur - trial : cur;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j+1] <= 1'b0;
      end else if (en_i) begin
        v_q[j+1] <= v_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j+1]  <= nrem[REM_W-1:0];
        root_q[j+1] <= {root_q[j][RW-2:0], ge};
        sv_q[j+1]   <= {sv_q[j][QW-3:0], 2'b00};
        big_q[j+1]  <= big_q[j];
        tag_q[j+1]  <= tag_q[j];
      end
    end
  end

  assign valid_o = v_q[NS];
  assign k_o     = big_q[NS] ? {root_q[NS], 4'h0} : {4'h0, root_q[NS]};
  assign tag_o   = tag_q[NS];

endmodule

/* design/gpt_scale.sv */
module gpt_scale #(
  parameter int unsigned UNIFORM_BITS = gpt_pkg::UNIFORM_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              en_i,
  input  logic                              valid_i,
  input  logic signed [UNIFORM_BITS-1:0]    x_i,
  input  logic [gpt_pkg::K_W-1:0]           k_i,
  input  logic signed [gpt_pkg::MEAN_W-1:0] mean_i,
  input  logic [gpt_pkg::STD_W-1:0]         std_dev_i,
  output logic                              valid_o,
  output logic [gpt_pkg::SAMPLE_W-1:0]      sample_o
);

  localparam int unsigned UB  = UNIFORM_BITS;
  localparam int unsigned F   = UB - 1;
  localparam int unsigned KS  = gpt_pkg::K_SPLIT;
  localparam int unsigned KW  = gpt_pkg::K_W;
  localparam int unsigned PW  = UB + KW;
  localparam int unsigned SW  = gpt_pkg::SAMPLE_W;
  localparam int unsigned MW  = gpt_pkg::MAG_W;
  localparam int unsigned SUW = gpt_pkg::SUM_W;
  localparam int unsigned STW = gpt_pkg::STD_W;

  logic            v1_q, v2_q, v3_q, v4_q;
  logic            n1_q, n2_q, n3_q;
  logic [UB-1:0]   ax;
  logic [UB+KS-1:0]      pl_q;
  logic [UB+KW-KS-1:0]   ph_q;
  logic [PW-1:0]   prod;
  logic [PW-F-1:0] p_full;
  logic [SW-1:0]   p_q;
  logic [SW+STW-1:0] m_q;
  logic [MW-1:0]   mag;
  logic signed [SUW-1:0] sum;
  logic [SW-1:0]   sample_q;
  logic [SW-1:0]   sample_d;

  assign ax     = x_i[UB-1] ? (~x_i + 1'b1) : x_i;
  assign prod   = {ph_q, {KS{1'b0}}} + PW'(pl_q);
  assign p_full = prod[PW-1:F];
  assign mag    = m_q[SW+STW-1:16];

  always_comb begin
    sum = SUW'(mean_i) + (n3_q ? -$signed({2'b00, mag}) : $signed({2'b00, mag}));
    if (sum > $signed(SUW'(32'h7FFF_FFFF))) begin
      sample_d = 32'h7FFF_FFFF;
    end else if (sum < -$signed(SUW'(33'h1_0000_0000 >> 1))) begin
      sample_d = 32'h8000_0000;
    end else begin
      sample_d = sum[SW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pl_q     <= ax * k_i[KS-1:0];
      ph_q     <= ax * k_i[KW-1:KS];
      n1_q     <= x_i[UB-1];
      p_q      <= (|p_full[PW-F-1:SW]) ? {SW{1'b1}} : p_full[SW-1:0];
      n2_q     <= n1_q;
      m_q      <= p_q * std_dev_i;
      n3_q     <= n2_q;
      sample_q <= sample_d;
    end
  end

  assign valid_o  = v4_q;
  assign sample_o = sample_q;

endmodule
